>>> rtl/core/assert_macros.svh
// Assertion macros shared by the scanner RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sbbs_pkg.sv
// Package for the bracket balance scanner: widths, lexer mode codes,
// character codes and counter helpers. No dependencies.
package sbbs_pkg;

    localparam int DEPTH_BITS = 16;
    localparam int RPT_W      = 16;
    localparam int EXT_W      = (DEPTH_BITS > RPT_W) ? DEPTH_BITS : RPT_W;

    typedef logic        [7:0]            t_byte;
    typedef logic        [1:0]            t_mode;
    typedef logic signed [DEPTH_BITS-1:0] t_count;
    typedef logic signed [RPT_W-1:0]      t_depth;

    localparam t_mode MODE_CODE   = 2'd0;
    localparam t_mode MODE_LINE   = 2'd1;
    localparam t_mode MODE_BLOCK  = 2'd2;
    localparam t_mode MODE_STRING = 2'd3;

    localparam t_byte CH_LPAREN = 8'h28;
    localparam t_byte CH_RPAREN = 8'h29;
    localparam t_byte CH_LCURLY = 8'h7B;
    localparam t_byte CH_RCURLY = 8'h7D;
    localparam t_byte CH_LSQUARE = 8'h5B;
    localparam t_byte CH_RSQUARE = 8'h5D;
    localparam t_byte CH_NEWLINE = 8'h0A;
    localparam t_byte CH_BSLASH = 8'h5C;
    localparam t_byte CH_SLASH  = 8'h2F;
    localparam t_byte CH_STAR   = 8'h2A;
    localparam t_byte CH_DQUOTE = 8'h22;
    localparam t_byte CH_SQUOTE = 8'h27;

    localparam t_count CNT_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam t_count CNT_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam t_count CNT_ZERO = '0;

    localparam logic signed [EXT_W-1:0] RPT_MAX_X = EXT_W'(32'sd32767);
    localparam logic signed [EXT_W-1:0] RPT_MIN_X = EXT_W'(-32'sd32768);

    // Saturating step of one bracket counter.
    function automatic t_count bump(t_count v, logic up);
        t_count r;
        r = v;
        if (up) begin
            if (v != CNT_MAX) r = v + t_count'(1);
        end else begin
            if (v != CNT_MIN) r = v - t_count'(1);
        end
        return r;
    endfunction

    // Clamp a counter to the 16-bit reported range.
    function automatic t_depth clamp_report(t_count v);
        logic signed [EXT_W-1:0] x;
        x = EXT_W'(v);
        if (x > RPT_MAX_X) x = RPT_MAX_X;
        if (x < RPT_MIN_X) x = RPT_MIN_X;
        return x[RPT_W-1:0];
    endfunction

endpackage

>>> rtl/core/sbbs_in_if.sv
// Input channel of the scanner: one text byte and its last-byte flag.
// Depends on sbbs_pkg.
interface sbbs_in_if;
    import sbbs_pkg::*;

    logic  valid;
    logic  ready;
    t_byte text_byte;
    logic  end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

>>> rtl/core/sbbs_out_if.sv
// Result channel of the scanner: open-scope flags and final bracket depths.
// Depends on sbbs_pkg.
interface sbbs_out_if;
    import sbbs_pkg::*;

    logic   valid;
    logic   ready;
    logic   unclosed;
    logic   open_string;
    logic   open_block_comment;
    t_depth round_depth;
    t_depth curly_depth;
    t_depth square_depth;

    modport source (output valid, output unclosed, output open_string,
                    output open_block_comment, output round_depth,
                    output curly_depth, output square_depth, input ready);
    modport sink   (input valid, input unclosed, input open_string,
                    input open_block_comment, input round_depth,
                    input curly_depth, input square_depth, output ready);
endinterface

>>> rtl/core/source_bracket_balance_scanner_unit.sv
// Throughput: one text byte per cycle while no held result stalls; the lexer state
// updates in a single step. A last byte's result is captured in the result register
// as the byte leaves the input register; a held result stalls only a last byte.
// Reset (i_rst_n low, synchronous) empties both registers and returns the lexer
// to code mode with zero bracket counts; the state also clears after each last byte.
// Depends on sbbs_pkg, sbbs_in_if, sbbs_out_if and assert_macros.svh.
`include "assert_macros.svh"

module source_bracket_balance_scanner_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sbbs_in_if.sink           i_text,
    sbbs_out_if.source        o_result
);
    import sbbs_pkg::*;

    // input register
    logic   r_in_valid;
    t_byte  r_in_byte;
    logic   r_in_last;

    // lexer state
    t_mode  r_mode,  n_mode;
    logic   r_pslash, n_pslash;
    logic   r_pstar, n_pstar;
    logic   r_esc, n_esc;
    logic   r_qsingle, n_qsingle;
    t_count r_round, n_round;
    t_count r_curly, n_curly;
    t_count r_square, n_square;

    // result register
    logic   r_out_valid;
    logic   r_unclosed;
    logic   r_open_str;
    logic   r_open_blk;
    t_depth r_round_d;
    t_depth r_curly_d;
    t_depth r_square_d;

    logic   consume;
    logic   code_go;
    logic   n_unclosed;

    assign consume = r_in_valid && (!r_in_last || !r_out_valid || o_result.ready);
    assign i_text.ready = !r_in_valid || consume;

    always_comb begin
        n_mode    = r_mode;
        n_pslash  = r_pslash;
        n_pstar   = r_pstar;
        n_esc     = r_esc;
        n_qsingle = r_qsingle;
        n_round   = r_round;
        n_curly   = r_curly;
        n_square  = r_square;
        code_go   = 1'b0;
        unique case (r_mode)
            MODE_LINE: begin
                if (r_in_byte == CH_NEWLINE) n_mode = MODE_CODE;
            end
            MODE_BLOCK: begin
                if (r_pstar && (r_in_byte == CH_SLASH)) begin
                    n_pstar = 1'b0;
                    n_mode  = MODE_CODE;
                end else begin
                    n_pstar = (r_in_byte == CH_STAR);
                end
            end
            MODE_STRING: begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (r_in_byte == CH_BSLASH) begin
                    n_esc = 1'b1;
                end else if (r_in_byte == (r_qsingle ? CH_SQUOTE : CH_DQUOTE)) begin
                    n_mode    = MODE_CODE;
                    n_qsingle = 1'b0;
                end
            end
            MODE_CODE: begin
                code_go = 1'b1;
                if (r_pslash) begin
                    n_pslash = 1'b0;
                    if (r_in_byte == CH_SLASH) begin
                        n_mode  = MODE_LINE;
                        code_go = 1'b0;
                    end else if (r_in_byte == CH_STAR) begin
                        n_mode  = MODE_BLOCK;
                        n_pstar = 1'b0;
                        code_go = 1'b0;
                    end
                end
                if (code_go) begin
                    priority if (r_in_byte == CH_SLASH) begin
                        n_pslash = 1'b1;
                    end else if ((r_in_byte == CH_DQUOTE) || (r_in_byte == CH_SQUOTE)) begin
                        n_mode    = MODE_STRING;
                        n_qsingle = (r_in_byte == CH_SQUOTE);
                        n_esc     = 1'b0;
                    end else if (r_in_byte == CH_LPAREN) begin
                        n_round = bump(r_round, 1'b1);
                    end else if (r_in_byte == CH_RPAREN) begin
                        n_round = bump(r_round, 1'b0);
                    end else if (r_in_byte == CH_LCURLY) begin
                        n_curly = bump(r_curly, 1'b1);
                    end else if (r_in_byte == CH_RCURLY) begin
                        n_curly = bump(r_curly, 1'b0);
                    end else if (r_in_byte == CH_LSQUARE) begin
                        n_square = bump(r_square, 1'b1);
                    end else if (r_in_byte == CH_RSQUARE) begin
                        n_square = bump(r_square, 1'b0);
                    end else begin
                        n_pslash = 1'b0;
                    end
                end
            end
        endcase
    end

    assign n_unclosed = (n_mode == MODE_STRING) || (n_mode == MODE_BLOCK) ||
                        (n_round > CNT_ZERO) || (n_curly > CNT_ZERO) ||
                        (n_square > CNT_ZERO);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
        if (i_text.ready && i_text.valid) begin
            r_in_byte <= i_text.text_byte;
            r_in_last <= i_text.end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (consume && r_in_last)) begin
            r_mode    <= MODE_CODE;
            r_pslash  <= 1'b0;
            r_pstar   <= 1'b0;
            r_esc     <= 1'b0;
            r_qsingle <= 1'b0;
            r_round   <= CNT_ZERO;
            r_curly   <= CNT_ZERO;
            r_square  <= CNT_ZERO;
        end else if (consume) begin
            r_mode    <= n_mode;
            r_pslash  <= n_pslash;
            r_pstar   <= n_pstar;
            r_esc     <= n_esc;
            r_qsingle <= n_qsingle;
            r_round   <= n_round;
            r_curly   <= n_curly;
            r_square  <= n_square;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (consume && r_in_last) begin
            r_unclosed <= n_unclosed;
            r_open_str <= (n_mode == MODE_STRING);
            r_open_blk <= (n_mode == MODE_BLOCK);
            r_round_d  <= clamp_report(n_round);
            r_curly_d  <= clamp_report(n_curly);
            r_square_d <= clamp_report(n_square);
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.unclosed           = r_unclosed;
    assign o_result.open_string        = r_open_str;
    assign o_result.open_block_comment = r_open_blk;
    assign o_result.round_depth        = r_round_d;
    assign o_result.curly_depth        = r_curly_d;
    assign o_result.square_depth       = r_square_d;

    `ASSERT_IMPL(a_result_source, i_clk, i_rst_n, $rose(r_out_valid),
                 $past(r_in_valid && r_in_last), "result without a last item")
    `ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, consume && r_in_last,
                 (r_mode == MODE_CODE) && (r_round == CNT_ZERO) && (r_curly == CNT_ZERO) &&
                 (r_square == CNT_ZERO) && !r_pslash && !r_esc,
                 "state not cleared after last item")
    `ASSERT_IMPL(a_unclosed_match, i_clk, i_rst_n, r_out_valid,
                 r_unclosed == (r_open_str || r_open_blk || (r_round_d > 0) ||
                                (r_curly_d > 0) || (r_square_d > 0)),
                 "unclosed flag disagrees with result")
    `ASSERT_IMPL(a_single_scope, i_clk, i_rst_n, r_out_valid,
                 !(r_open_str && r_open_blk), "string and block comment both open")

endmodule
